// File: rtl/mgrle_pkg.sv
package mgrle_pkg;

    // Line store geometry
    localparam int MAX_LINE_WIDTH = 4096;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int FILL_W         = COL_W + 1;

    // Line width register and the width used for clamping
    localparam int LW_W = 13;
    localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 13'd640;
    localparam int W_W = (LW_W > COL_W + 1) ? LW_W : COL_W + 1;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int CODE_W = 18;
    localparam int LEN_W  = 5;
    localparam int FOLD_W = PIX_W + 1;
    localparam int K_W    = 4;
    localparam int LOG_W  = FOLD_W + 1;
    localparam int RV_W   = (COL_W > FOLD_W) ? COL_W : FOLD_W;

    // Code constants
    localparam int ESC_Q    = 9;
    localparam int ESC_BITS = 9;
    localparam int ESC_LEN  = ESC_Q + ESC_BITS;
    localparam int RUN_K    = 3;
    localparam int RAW_BITS = 8;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pixel_in;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic              last;
    } t_code_word;

    // Pixel held in the input stage, handed to the coder
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             col_zero;
        logic             end_line;
    } t_s1_item;

    // Up to two code words produced for one pixel
    typedef struct packed {
        logic [1:0] count;
        t_code_word word0;
        t_code_word word1;
    } t_coder_out;

    // Rice code of v with parameter k, escape when the quotient reaches ESC_Q
    function automatic t_code_word rice(input logic [RV_W-1:0] v, input logic [K_W-1:0] k);
        logic [RV_W-1:0]   q;
        logic [CODE_W-1:0] top;
        logic [CODE_W-1:0] vx;
        t_code_word        r;
        q   = v >> k;
        top = CODE_W'(1) << k;
        vx  = CODE_W'(v);
        r.last = 1'b0;
        if (q < RV_W'(ESC_Q)) begin
            r.code_bits   = top | (vx & (top - CODE_W'(1)));
            r.code_length = LEN_W'(q) + LEN_W'(k) + LEN_W'(1);
        end else begin
            r.code_bits   = (top | vx) & CODE_W'((1 << ESC_BITS) - 1);
            r.code_length = LEN_W'(ESC_LEN);
        end
        return r;
    endfunction

endpackage

// File: rtl/mgrle_ram.sv
module mgrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mgrle_coder.sv
module mgrle_coder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_proc,
    input  mgrle_pkg::t_s1_item           i_item,
    input  logic [mgrle_pkg::PIX_W-1:0]   i_upper,
    output mgrle_pkg::t_coder_out         o_out
);

    import mgrle_pkg::*;

    logic [PIX_W-1:0]  r_left;
    logic [PIX_W-1:0]  r_upper_left;
    logic [FOLD_W-1:0] r_last_fold;
    logic              r_in_run;
    logic [COL_W-1:0]  r_run_count;
    logic [PIX_W-1:0]  r_run_value;

    logic [PIX_W-1:0]  n_upper_left;
    logic [FOLD_W-1:0] n_last_fold;
    logic              n_in_run;
    logic [COL_W-1:0]  n_run_count;
    logic [PIX_W-1:0]  n_run_value;

    logic [PIX_W-1:0]  a, b, c, p;
    logic [PIX_W-1:0]  mx, mn, pred;
    logic [PIX_W+1:0]  sum_abc;
    logic signed [PIX_W:0] err;
    logic [PIX_W-1:0]  mag;
    logic [FOLD_W-1:0] fold;
    logic [LOG_W-1:0]  log_arg;
    logic [K_W-1:0]    k_reg;
    logic [COL_W-1:0]  run_v;
    t_code_word        reg_word;
    t_code_word        run_word;
    t_code_word        raw_word;
    t_coder_out        out;

    assign a = r_left;
    assign b = i_upper;
    assign c = r_upper_left;
    assign p = i_item.pixel;

    // MED prediction and error folding
    always_comb begin
        mx      = (a > b) ? a : b;
        mn      = (a > b) ? b : a;
        sum_abc = {2'b00, a} + {2'b00, b} - {2'b00, c};
        if (c >= mx) begin
            pred = mn;
        end else if (c <= mn) begin
            pred = mx;
        end else begin
            pred = sum_abc[PIX_W-1:0];
        end
        err = $signed({1'b0, p}) - $signed({1'b0, pred});
        if (err <= 0) begin
            mag  = PIX_W'(-err);
            fold = {mag, 1'b0};
        end else begin
            mag  = PIX_W'(err);
            fold = {mag, 1'b0} - FOLD_W'(1);
        end
    end

    // Rice parameter: floor(log2(last folded error + 1)), at least 1
    always_comb begin
        log_arg = LOG_W'(r_last_fold) + LOG_W'(1);
        k_reg   = K_W'(1);
        for (int i = 2; i < LOG_W; i++) begin
            if (log_arg[i]) begin
                k_reg = K_W'(i);
            end
        end
    end

    // Run length that a closing run would send
    always_comb begin
        if (r_in_run) begin
            run_v = (p == r_run_value) ? r_run_count + COL_W'(1) : r_run_count;
        end else begin
            run_v = (p == a) ? COL_W'(1) : '0;
        end
    end

    assign reg_word = rice(RV_W'(fold), k_reg);
    assign run_word = rice(RV_W'(run_v), K_W'(RUN_K));

    always_comb begin
        raw_word.code_bits   = CODE_W'(p);
        raw_word.code_length = LEN_W'(RAW_BITS);
        raw_word.last        = 1'b0;
    end

    // Mode selection and next state
    always_comb begin
        n_upper_left = b;
        n_last_fold  = r_last_fold;
        n_in_run     = r_in_run;
        n_run_count  = r_run_count;
        n_run_value  = r_run_value;
        out          = '0;
        if (i_item.col_zero) begin
            out.count   = 2'd1;
            out.word0   = raw_word;
            n_last_fold = '0;
            n_in_run    = 1'b0;
            n_run_count = '0;
        end else if (r_in_run) begin
            if (p == r_run_value) begin
                n_run_count = run_v;
                if (i_item.end_line) begin
                    out.count = 2'd1;
                    out.word0 = run_word;
                    n_in_run  = 1'b0;
                end
            end else begin
                out.count   = 2'd2;
                out.word0   = run_word;
                out.word1   = reg_word;
                n_last_fold = fold;
                n_in_run    = 1'b0;
            end
        end else if (a == b && b == c) begin
            if (p == a) begin
                n_in_run    = 1'b1;
                n_run_value = a;
                n_run_count = run_v;
                if (i_item.end_line) begin
                    out.count = 2'd1;
                    out.word0 = run_word;
                    n_in_run  = 1'b0;
                end
            end else begin
                // zero-length run, then the pixel itself
                out.count   = 2'd2;
                out.word0   = run_word;
                out.word1   = reg_word;
                n_last_fold = fold;
            end
        end else begin
            out.count   = 2'd1;
            out.word0   = reg_word;
            n_last_fold = fold;
        end
        out.word0.last = (out.count == 2'd1);
        out.word1.last = 1'b1;
    end

    // Context state, advanced once per coded pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_upper_left <= '0;
            r_last_fold  <= '0;
            r_in_run     <= 1'b0;
            r_run_count  <= '0;
            r_run_value  <= '0;
        end else if (i_proc) begin
            r_left       <= p;
            r_upper_left <= n_upper_left;
            r_last_fold  <= n_last_fold;
            r_in_run     <= n_in_run;
            r_run_count  <= n_run_count;
            r_run_value  <= n_run_value;
        end
    end

    assign o_out = out;

endmodule

// File: rtl/med_golomb_rice_line_encoder.sv
// MED-predicted Golomb-Rice line encoder. Takes one 8-bit pixel per transaction in raster
// order and returns variable-length code words (value plus length, sent MSB first), with
// last set on the final word of each pixel; a pixel inside a run returns no word, a pixel
// that breaks a run with a different value or sees a zero-length run returns two. One
// pixel is taken every cycle while o_stall is low: the pixel is registered together with
// the registered read of the previous-line store, coded from that input stage and pushed
// into a four-word output queue once the queue has room. The output port moves one word per
// cycle while i_stall is low, and the input stalls only when the queue cannot hold two
// more words. The line store needs no clearing pass: a fill count marks
// which columns were written since the last frame start, and the rest read as zero.
// line_width may only be written while the encoder is empty; values below 2 act as 2 and
// values above 4096 act as 4096.
module med_golomb_rice_line_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  mgrle_pkg::t_pixel_in           i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output mgrle_pkg::t_code_word          o_data,
    input  logic                           i_cfg_wr_en,
    input  logic [mgrle_pkg::LW_W-1:0]     i_cfg_wr_data
);

    import mgrle_pkg::*;

    logic [LW_W-1:0]       r_line_width;
    logic [COL_W-1:0]      r_column;
    logic [FILL_W-1:0]     r_fill;
    logic                  r_s1_valid;
    t_s1_item              r_s1;
    logic [COL_W-1:0]      r_s1_col;
    logic                  r_s1_upper_ok;
    t_code_word            r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    logic [COL_W-1:0]      n_column;
    logic [FILL_W-1:0]     n_fill;

    logic                  accept_in;
    logic                  pop;
    logic                  room;
    logic                  proc;
    logic [W_W-1:0]        lw_ext;
    logic [W_W-1:0]        width;
    logic [W_W-1:0]        col_src;
    logic [W_W-1:0]        col_ext;
    logic [COL_W-1:0]      col;
    logic                  end_line;
    logic                  upper_ok;
    logic [PIX_W-1:0]      ram_rdata;
    logic [PIX_W-1:0]      upper;
    t_coder_out            coder_out;
    logic [FIFO_CNT_W-1:0] push_n;

    // Handshake
    assign pop       = o_valid && !i_stall;
    assign room      = (r_count - FIFO_CNT_W'(pop)) <= FIFO_CNT_W'(2);
    assign proc      = r_s1_valid && room;
    assign o_stall   = r_s1_valid && !room;
    assign accept_in = i_valid && !o_stall;

    // Column tracking with width clamping
    always_comb begin
        lw_ext = W_W'(r_line_width);
        if (lw_ext < W_W'(2)) begin
            width = W_W'(2);
        end else if (lw_ext > W_W'(MAX_LINE_WIDTH)) begin
            width = W_W'(MAX_LINE_WIDTH);
        end else begin
            width = lw_ext;
        end
        col_src  = i_data.frame_start ? '0 : W_W'(r_column);
        col_ext  = (col_src >= width) ? width - W_W'(1) : col_src;
        col      = col_ext[COL_W-1:0];
        end_line = (col_ext + W_W'(1)) >= width;
        n_column = end_line ? '0 : col + COL_W'(1);
    end

    // Fill count: columns below it hold data of the current frame
    always_comb begin
        upper_ok = !i_data.frame_start && (FILL_W'(col) < r_fill);
        if (i_data.frame_start) begin
            n_fill = FILL_W'(1);
        end else if (FILL_W'(col) + FILL_W'(1) > r_fill) begin
            n_fill = FILL_W'(col) + FILL_W'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    // Previous-line store: read on accept, written when the pixel is coded
    mgrle_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (proc),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1.pixel),
        .i_re    (accept_in),
        .i_raddr (col),
        .o_rdata (ram_rdata)
    );

    assign upper = r_s1_upper_ok ? ram_rdata : '0;

    mgrle_coder u_coder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_proc  (proc),
        .i_item  (r_s1),
        .i_upper (upper),
        .o_out   (coder_out)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
            r_column     <= '0;
            r_fill       <= '0;
            r_s1_valid   <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_line_width <= i_cfg_wr_data;
            end
            if (accept_in) begin
                r_column   <= n_column;
                r_fill     <= n_fill;
                r_s1_valid <= 1'b1;
            end else if (proc) begin
                r_s1_valid <= 1'b0;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(push_n);
            r_count  <= r_count - FIFO_CNT_W'(pop) + push_n;
        end
    end

    assign push_n = proc ? FIFO_CNT_W'(coder_out.count) : '0;

    // Input stage payload
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1.pixel    <= i_data.pixel;
            r_s1.col_zero <= (col == '0);
            r_s1.end_line <= end_line;
            r_s1_col      <= col;
            r_s1_upper_ok <= upper_ok;
        end
    end

    // Output queue storage
    always_ff @(posedge i_clk) begin
        if (proc && coder_out.count != 2'd0) begin
            r_fifo[r_wr_ptr] <= coder_out.word0;
        end
        if (proc && coder_out.count == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_PTR_W'(1)] <= coder_out.word1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_fifo[r_rd_ptr];

    // Checks
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("output queue overfilled");

    a_line_start_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_s1.col_zero) |-> (coder_out.count == 2'd1))
        else $error("line start pixel must give exactly one word");

    a_frame_start_col0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept_in && i_data.frame_start) |=> r_s1.col_zero)
        else $error("frame start pixel not at column zero");

    a_fill_covers_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in |=> (FILL_W'(r_s1_col) < r_fill))
        else $error("fill count behind accepted column");

endmodule
